FILE: src/knms_pkg.sv
package knms_pkg;

   // Field widths fixed by the item format
   localparam int DIST_BITS      = 21;
   localparam int KEPT_BITS      = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = DIST_BITS;

   // Defaults for the top-level parameters
   localparam int MAX_NEIGHBORS_DEF = 8;
   localparam int INDEX_BITS_DEF    = 10;

   // Register reset values
   localparam logic [DIST_BITS-1:0] DISTANCE_LIMIT_RESET = DIST_BITS'(40000);
   localparam logic [KEPT_BITS-1:0] NEIGHBORS_KEPT_RESET = KEPT_BITS'(5);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISTANCE_LIMIT = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBORS_KEPT = CSR_INDEX_BITS'(1);

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT
   } knms_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic scan_step;
      logic replace;
      logic emit_step;
   } knms_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic over_limit;
      logic scan_done;
      logic scan_hit;
      logic end_flag;
      logic any_filled;
      logic out_free;
   } knms_status_type;

endpackage

FILE: src/knms_if.sv
// Candidate stream channel
interface knms_req_if
   import knms_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] query_index;
   logic [INDEX_BITS-1:0] candidate_index;
   logic [DIST_BITS-1:0]  pair_distance;
   logic                  end_of_candidates;

   modport source (
      output valid, query_index, candidate_index, pair_distance, end_of_candidates,
      input  ready
   );
   modport sink (
      input  valid, query_index, candidate_index, pair_distance, end_of_candidates,
      output ready
   );
endinterface

// Match result channel
interface knms_rsp_if
   import knms_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] match_query;
   logic [INDEX_BITS-1:0] match_candidate;
   logic [DIST_BITS-1:0]  match_distance;
   logic                  last_match;

   modport source (
      output valid, match_query, match_candidate, match_distance, last_match,
      input  ready
   );
   modport sink (
      input  valid, match_query, match_candidate, match_distance, last_match,
      output ready
   );
endinterface

FILE: src/knms_ctrl.sv
module knms_ctrl
   import knms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  knms_status_type status,
   output knms_cmd_type    cmd
);

   knms_state_type state_ff;
   knms_state_type state_in;
   knms_state_type finish_state;

   // After the item is handled: emit on the flagged item, else wait for the next one
   assign finish_state = status.end_flag ? ST_EMIT : ST_IDLE;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.over_limit)     state_in = finish_state;
            else if (status.scan_done) state_in = ST_UPDATE;
            else if (status.scan_hit)  state_in = finish_state;
         end
         ST_UPDATE: begin
            state_in = finish_state;
         end
         ST_EMIT: begin
            if (!status.any_filled) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = !status.over_limit && !status.scan_done;
         end
         ST_UPDATE: begin
            cmd.replace = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_step = status.any_filled && status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/knms_datapath.sv
module knms_datapath
   import knms_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // config
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   // incoming item
   input  logic [INDEX_BITS-1:0]     in_query,
   input  logic [INDEX_BITS-1:0]     in_candidate,
   input  logic [DIST_BITS-1:0]      in_distance,
   input  logic                      in_end,
   // outgoing result
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [INDEX_BITS-1:0]     out_query,
   output logic [INDEX_BITS-1:0]     out_candidate,
   output logic [DIST_BITS-1:0]      out_distance,
   output logic                      out_last,
   // control
   input  knms_cmd_type              cmd,
   output knms_status_type           status
);

   localparam int SLOT_BITS  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_NEIGHBORS + 1);
   localparam int CMP_BITS   = (COUNT_BITS > KEPT_BITS) ? COUNT_BITS : KEPT_BITS;

   // Config registers
   logic [DIST_BITS-1:0] limit_ff;
   logic [KEPT_BITS-1:0] kept_ff;

   // Item under work
   logic [INDEX_BITS-1:0] query_ff;
   logic [INDEX_BITS-1:0] cand_ff;
   logic [DIST_BITS-1:0]  dist_ff;
   logic                  end_ff;

   // Slot store
   logic [MAX_NEIGHBORS-1:0] filled_ff;
   logic [MAX_NEIGHBORS-1:0] filled_in;
   logic [DIST_BITS-1:0]     slot_dist_ff [MAX_NEIGHBORS];
   logic [INDEX_BITS-1:0]    slot_cand_ff [MAX_NEIGHBORS];

   // Scan state
   logic [COUNT_BITS-1:0] idx_ff;
   logic [COUNT_BITS-1:0] idx_in;
   logic                  have_worst_ff;
   logic                  have_worst_in;
   logic [SLOT_BITS-1:0]  worst_slot_ff;
   logic [SLOT_BITS-1:0]  worst_slot_in;
   logic [DIST_BITS-1:0]  worst_dist_ff;
   logic [DIST_BITS-1:0]  worst_dist_in;

   // Output register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [INDEX_BITS-1:0] out_query_ff;
   logic [INDEX_BITS-1:0] out_cand_ff;
   logic [DIST_BITS-1:0]  out_dist_ff;
   logic                  out_last_ff;

   logic [CMP_BITS-1:0]      kept_ext;
   logic [CMP_BITS-1:0]      max_ext;
   logic [CMP_BITS-1:0]      usable_ext;
   logic [COUNT_BITS-1:0]    usable_count;
   logic [SLOT_BITS-1:0]     scan_slot;
   logic [SLOT_BITS-1:0]     emit_sel;
   logic [MAX_NEIGHBORS-1:0] emit_mask;
   logic                     others_filled;
   logic [SLOT_BITS-1:0]     rd_slot;
   logic [DIST_BITS-1:0]     rd_dist;
   logic [INDEX_BITS-1:0]    rd_cand;
   logic                     scan_hit;
   logic                     do_fill;
   logic                     do_replace;

   // Slot count in use, saturated at the store depth
   assign kept_ext     = CMP_BITS'(kept_ff);
   assign max_ext      = CMP_BITS'(MAX_NEIGHBORS);
   assign usable_ext   = (kept_ext > max_ext) ? max_ext : kept_ext;
   assign usable_count = COUNT_BITS'(usable_ext);

   assign scan_slot = idx_ff[SLOT_BITS-1:0];
   assign scan_hit  = !filled_ff[scan_slot];

   // Lowest filled slot goes out first
   always_comb begin
      emit_sel = '0;
      for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
         if (filled_ff[i]) emit_sel = SLOT_BITS'(i);
      end
      emit_mask           = '0;
      emit_mask[emit_sel] = 1'b1;
      others_filled       = |(filled_ff & ~emit_mask);
   end

   // Single slot read port, shared by scan and emit
   assign rd_slot = cmd.emit_step ? emit_sel : scan_slot;
   assign rd_dist = slot_dist_ff[rd_slot];
   assign rd_cand = slot_cand_ff[rd_slot];

   assign do_fill    = cmd.scan_step && scan_hit;
   assign do_replace = cmd.replace && have_worst_ff && (dist_ff < worst_dist_ff);

   // Status back to the controller
   always_comb begin
      status.over_limit = dist_ff > limit_ff;
      status.scan_done  = idx_ff >= usable_count;
      status.scan_hit   = scan_hit;
      status.end_flag   = end_ff;
      status.any_filled = |filled_ff;
      status.out_free   = !out_valid_ff || out_ready;
   end

   // Scan counter and running largest distance
   always_comb begin
      idx_in        = idx_ff;
      have_worst_in = have_worst_ff;
      worst_slot_in = worst_slot_ff;
      worst_dist_in = worst_dist_ff;
      if (cmd.load_item) begin
         idx_in        = '0;
         have_worst_in = 1'b0;
      end else if (cmd.scan_step && !scan_hit) begin
         idx_in = idx_ff + COUNT_BITS'(1);
         if (!have_worst_ff || rd_dist > worst_dist_ff) begin
            have_worst_in = 1'b1;
            worst_slot_in = scan_slot;
            worst_dist_in = rd_dist;
         end
      end
   end

   // Filled bits: set on fill, cleared as each slot goes out
   always_comb begin
      filled_in = filled_ff;
      if (do_fill) filled_in[scan_slot] = 1'b1;
      if (cmd.emit_step) filled_in[emit_sel] = 1'b0;
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit_step)     out_valid_in = 1'b1;
      else if (out_ready)    out_valid_in = 1'b0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= DISTANCE_LIMIT_RESET;
         kept_ff       <= NEIGHBORS_KEPT_RESET;
         filled_ff     <= '0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         have_worst_ff <= 1'b0;
      end else begin
         filled_ff     <= filled_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
         have_worst_ff <= have_worst_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DISTANCE_LIMIT: limit_ff <= csr_write_data[DIST_BITS-1:0];
               CSR_NEIGHBORS_KEPT: kept_ff  <= csr_write_data[KEPT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      worst_slot_ff <= worst_slot_in;
      worst_dist_ff <= worst_dist_in;
      if (cmd.load_item) begin
         query_ff <= in_query;
         cand_ff  <= in_candidate;
         dist_ff  <= in_distance;
         end_ff   <= in_end;
      end
      if (do_fill) begin
         slot_dist_ff[scan_slot] <= dist_ff;
         slot_cand_ff[scan_slot] <= cand_ff;
      end else if (do_replace) begin
         slot_dist_ff[worst_slot_ff] <= dist_ff;
         slot_cand_ff[worst_slot_ff] <= cand_ff;
      end
      if (cmd.emit_step) begin
         out_query_ff <= query_ff;
         out_cand_ff  <= rd_cand;
         out_dist_ff  <= rd_dist;
         out_last_ff  <= !others_filled;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_query     = out_query_ff;
   assign out_candidate = out_cand_ff;
   assign out_distance  = out_dist_ff;
   assign out_last      = out_last_ff;

endmodule

FILE: src/k_nearest_match_selector_unit.sv
// K-nearest match selector. Takes (query, candidate, distance) beats, keeps the
// neighbors_kept smallest distances not above distance_limit in a slot store of
// MAX_NEIGHBORS entries, and on the beat flagged end_of_candidates sends every
// kept match in slot order, the final one with last_match set. The block takes
// a candidate beat while idle, then the controller walks the slot store one slot
// per cycle through a single read port, sees the end of the walk and does the
// replacement write; a distance over the limit or a free slot ends the walk
// early. At the end of a query the store drains one match per cycle while the
// result side takes beats, then the controller returns to idle. The result
// register lets the next candidate be taken while the last match waits.
module k_nearest_match_selector_unit
   import knms_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   knms_req_if.sink                  req,
   knms_rsp_if.source                rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   knms_cmd_type    cmd;
   knms_status_type status;

   // Sequencer
   knms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Slot store, compare and result register
   knms_datapath #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .INDEX_BITS    (INDEX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_query         (req.query_index),
      .in_candidate     (req.candidate_index),
      .in_distance      (req.pair_distance),
      .in_end           (req.end_of_candidates),
      .out_valid        (rsp.valid),
      .out_ready        (rsp.ready),
      .out_query        (rsp.match_query),
      .out_candidate    (rsp.match_candidate),
      .out_distance     (rsp.match_distance),
      .out_last         (rsp.last_match),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

FILE: src/knms_checker.sv
module knms_checker
   import knms_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_end,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [INDEX_BITS-1:0] rsp_candidate,
   input logic [DIST_BITS-1:0]  rsp_distance,
   input logic                  rsp_last
);

   // A stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_candidate)
         && $stable(rsp_distance) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // No new candidate while a query's matches are still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("candidate taken during match drain");

   // A candidate that does not close a query keeps the block busy for its scan
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_end |=> !req_ready)
      else $error("ready right after an unflagged candidate");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind k_nearest_match_selector_unit knms_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_knms_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_end       (req.end_of_candidates),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_candidate (rsp.match_candidate),
   .rsp_distance  (rsp.match_distance),
   .rsp_last      (rsp.last_match)
);
